// ===== src/csv_line_tokenizer_unit_macros.svh =====
// Assertion helpers, sampled on clk and disabled while rst is high.
`ifndef CSV_LINE_TOKENIZER_UNIT_MACROS_SVH
`define CSV_LINE_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/clt_pkg.sv =====
package clt_pkg;

  typedef enum logic [2:0] {
    KIND_DATA         = 3'd0,
    KIND_FIELD        = 3'd1,
    KIND_FIELD_RECORD = 3'd2,
    KIND_DROP         = 3'd3,
    KIND_EMPTY        = 3'd4
  } clt_kind_t;

  typedef struct packed {
    logic      is_header;
    clt_kind_t kind;
    logic [7:0] data;
  } clt_item_t;

  typedef struct packed {
    logic [1:0] count;
    clt_item_t  item1;
    clt_item_t  item0;
  } clt_result_t;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic field_nonempty;
    logic last_was_delim;
    logic at_line_start;
    logic header_mode;
    logic line_done;
  } clt_state_t;

  localparam clt_state_t STATE_RESET = '{
    in_quotes: 1'b0, quote_pending: 1'b0, field_nonempty: 1'b0,
    last_was_delim: 1'b0, at_line_start: 1'b1, header_mode: 1'b0,
    line_done: 1'b0
  };

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_AT    = 8'h40;

  localparam logic [7:0] DELIM_RESET = CHAR_COMMA;

  // register index, taken from paddr[2]
  localparam logic REG_DELIMITER = 1'b0;

endpackage

// ===== src/clt_cfg.sv =====
module clt_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  delimiter
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= clt_pkg::DELIM_RESET;
    end else if (wr_en && paddr[2] == clt_pkg::REG_DELIMITER) begin
      delimiter <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[2] == clt_pkg::REG_DELIMITER) begin
      prdata = {24'd0, delimiter};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

// ===== src/clt_step.sv =====
module clt_step (
  input  clt_pkg::clt_state_t  state,
  input  logic [7:0]           delimiter,
  input  logic [7:0]           in_byte,
  input  logic                 line_last,
  output clt_pkg::clt_state_t  state_next,
  output clt_pkg::clt_result_t result
);

  always_comb begin
    clt_pkg::clt_state_t s;
    clt_pkg::clt_item_t  slot [2];
    logic [1:0]          n;
    logic [7:0]          d;
    logic [7:0]          d_end;
    logic                handled;
    logic                prev;

    s       = state;
    n       = 2'd0;
    handled = 1'b0;
    prev    = 1'b0;
    slot[0] = '0;
    slot[1] = '0;
    d       = state.header_mode ? clt_pkg::CHAR_COMMA : delimiter;
    d_end   = d;

    if (!s.line_done) begin
      // a quote held from the previous byte: doubled quote or close
      if (s.quote_pending) begin
        s.quote_pending = 1'b0;
        if (in_byte == clt_pkg::CHAR_QUOTE) begin
          slot[n[0]] = '{is_header: s.header_mode, kind: clt_pkg::KIND_DATA, data: in_byte};
          n = n + 2'd1;
          s.field_nonempty = 1'b1;
          s.last_was_delim = (in_byte == d);
          handled = 1'b1;
        end else begin
          s.in_quotes = 1'b0;
        end
      end

      if (!handled) begin
        if (in_byte == clt_pkg::CHAR_NUL) begin
          prev = s.at_line_start ? (d == 8'd0) : s.last_was_delim;
          slot[n[0]] = '{is_header: s.header_mode,
                         kind: (s.field_nonempty || prev) ? clt_pkg::KIND_FIELD_RECORD
                                                          : clt_pkg::KIND_EMPTY,
                         data: 8'd0};
          n = n + 2'd1;
          s.line_done = 1'b1;
        end else if (!s.in_quotes && !s.field_nonempty && in_byte == clt_pkg::CHAR_QUOTE) begin
          s.in_quotes = 1'b1;
        end else if (s.in_quotes && in_byte == clt_pkg::CHAR_QUOTE) begin
          s.quote_pending = 1'b1;
        end else if (!s.in_quotes && in_byte == d) begin
          slot[n[0]] = '{is_header: s.header_mode, kind: clt_pkg::KIND_FIELD, data: 8'd0};
          n = n + 2'd1;
          s.field_nonempty = 1'b0;
        end else if (!s.in_quotes &&
                     (in_byte == clt_pkg::CHAR_CR || in_byte == clt_pkg::CHAR_LF)) begin
          slot[n[0]] = '{is_header: s.header_mode, kind: clt_pkg::KIND_FIELD_RECORD,
                         data: 8'd0};
          n = n + 2'd1;
          s.line_done = 1'b1;
        end else if (!s.in_quotes && in_byte == clt_pkg::CHAR_HASH) begin
          slot[n[0]] = '{is_header: s.header_mode, kind: clt_pkg::KIND_DROP, data: 8'd0};
          n = n + 2'd1;
          s.line_done = 1'b1;
        end else if (s.at_line_start && in_byte == clt_pkg::CHAR_AT) begin
          s.header_mode = 1'b1;
        end else begin
          slot[n[0]] = '{is_header: s.header_mode, kind: clt_pkg::KIND_DATA, data: in_byte};
          n = n + 2'd1;
          s.field_nonempty = 1'b1;
        end

        // a header '@' leaves the line start in place
        if (in_byte != clt_pkg::CHAR_NUL &&
            !(s.at_line_start && s.header_mode && in_byte == clt_pkg::CHAR_AT &&
              !s.in_quotes)) begin
          s.at_line_start  = 1'b0;
          s.last_was_delim = (in_byte == d);
        end
      end

      // implicit end of line; header mode may have just switched on
      if (line_last && !s.line_done) begin
        if (s.quote_pending) begin
          s.quote_pending = 1'b0;
          s.in_quotes     = 1'b0;
        end
        d_end = s.header_mode ? clt_pkg::CHAR_COMMA : delimiter;
        prev  = s.at_line_start ? (d_end == 8'd0) : s.last_was_delim;
        slot[n[0]] = '{is_header: s.header_mode,
                       kind: (s.field_nonempty || prev) ? clt_pkg::KIND_FIELD_RECORD
                                                        : clt_pkg::KIND_EMPTY,
                       data: 8'd0};
        n = n + 2'd1;
        s.line_done = 1'b1;
      end
    end

    if (line_last) begin
      s = clt_pkg::STATE_RESET;
    end

    state_next   = s;
    result.count = n;
    result.item0 = slot[0];
    result.item1 = slot[1];
  end

endmodule

// ===== src/clt_outq.sv =====
// Result queue; DEPTH is a power of two, at least 2.
module clt_outq #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  clt_pkg::clt_result_t push_data,
  output logic                 has_room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clt_pkg::clt_item_t   out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  clt_pkg::clt_item_t mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] push_cnt;
  logic          pop;

  assign pop      = out_valid && out_ready;
  assign push_cnt = push ? CW'(push_data.count) : '0;
  assign fill_next = fill + push_cnt - (pop ? CW'(1) : CW'(0));

  // room for the two results a single byte can produce
  assign has_room  = fill <= CW'(DEPTH - 2);
  assign out_valid = fill != '0;
  assign out_item  = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      tail <= tail + push_cnt[AW-1:0];
      if (pop) begin
        head <= head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_data.count != 2'd0) begin
      mem[tail] <= push_data.item0;
    end
    if (push && push_data.count == 2'd2) begin
      mem[tail + AW'(1)] <= push_data.item1;
    end
  end

endmodule

// ===== src/csv_line_tokenizer_unit.sv =====
// Output path: each accepted byte's events are registered in the result queue and presented on m_axis from there.
// Throughput: one byte per cycle while each byte yields at most one event and m_axis
//   is ready; the output port drains one event per cycle while ready, so bytes yielding
//   two events (end of line after a field) are paced by it through the result queue.
// Reset: synchronous rst clears line state and the queue, delimiter back to ','.
module csv_line_tokenizer_unit #(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // line_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [3:0]  m_axis_tuser,   // [2:0] event_kind, [3] is_header
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]           delimiter;
  clt_pkg::clt_state_t  state;
  clt_pkg::clt_state_t  state_next;
  clt_pkg::clt_result_t result;
  clt_pkg::clt_item_t   out_item;
  logic                 accept;
  logic                 has_room;

  clt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .delimiter (delimiter)
  );

  clt_step u_step (
    .state      (state),
    .delimiter  (delimiter),
    .in_byte    (s_axis_tdata),
    .line_last  (s_axis_tlast),
    .state_next (state_next),
    .result     (result)
  );

  clt_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .has_room  (has_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign s_axis_tready = has_room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = out_item.data;
  assign m_axis_tuser  = {out_item.is_header, out_item.kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clt_pkg::STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

`include "csv_line_tokenizer_unit_macros.svh"

  `CLT_ASSERT_NEXT(a_line_restart, accept && s_axis_tlast, state == clt_pkg::STATE_RESET, "line state not cleared after last byte")
  `CLT_ASSERT_NOW(a_pending_in_quotes, state.quote_pending, state.in_quotes, "quote pending outside quotes")
  `CLT_ASSERT_NOW(a_event_byte_zero, m_axis_tvalid && m_axis_tuser[2:0] != clt_pkg::KIND_DATA, m_axis_tdata == 8'd0, "boundary event carries a byte")

endmodule
